/* sv/led_grid_serial_command_parser_top_macros.svh */
// Assertion macros for the LED grid serial command parser.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef LED_GRID_SERIAL_COMMAND_PARSER_TOP_MACROS_SVH
`define LED_GRID_SERIAL_COMMAND_PARSER_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define LGSCP_ASSERT_IMM(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define LGSCP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LGSCP_ASSERT_IMM(lbl, ante, cons, msg)
`define LGSCP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/lgscp_pkg.sv */
// Shared types for the LED grid serial command parser.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package lgscp_pkg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_byte;   // take the received byte into the parser
        logic emit_step;   // produce the next pixel write
    } lgscp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic job_pending; // the byte being loaded causes pixel writes
        logic job_last;    // the write about to be produced is the final one
        logic slot_free;   // output register can take a write this cycle
    } lgscp_status_t;

endpackage

`default_nettype wire

/* sv/lgscp_rx_if.sv */
// Channel interfaces: received bytes in, pixel writes out.
// Depends on nothing; instantiated by the parent of the top level.
`default_nettype none

interface lgscp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface lgscp_pix_if;
    logic       valid;
    logic       ready;
    logic [3:0] pixel_index;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       last_write;

    modport source (output valid, output pixel_index, output red_level,
                    output green_level, output blue_level, output last_write,
                    input ready);
    modport sink (input valid, input pixel_index, input red_level,
                  input green_level, input blue_level, input last_write,
                  output ready);
endinterface

`default_nettype wire

/* sv/lgscp_datapath.sv */
// Parser state, pixel job registers and output register of the command parser.
// Depends on lgscp_pkg, lgscp_pix_if and the assertion macro header.
`default_nettype none
`include "led_grid_serial_command_parser_top_macros.svh"

module lgscp_datapath
    import lgscp_pkg::*;
#(
    parameter int GRID_SIDE = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    rx_byte,
    input  wire lgscp_cmd_t    cmd,
    output lgscp_status_t      status,
    lgscp_pix_if.source        pix
);

    localparam int IdxW      = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int PosW      = (2 * IdxW > 4) ? 2 * IdxW : 4;
    localparam int FillCount = (GRID_SIDE * GRID_SIDE > 16) ? 16 : GRID_SIDE * GRID_SIDE;
    localparam logic [3:0] FillLast = 4'(FillCount - 1);
    localparam logic [3:0] SideLast = 4'(GRID_SIDE - 1);
    localparam logic [3:0] SideNib  = 4'(GRID_SIDE);

    // Opcodes (high nibble of a command byte)
    localparam logic [3:0] OP_SET_COLOUR = 4'd1;
    localparam logic [3:0] OP_LED_ON     = 4'd2;
    localparam logic [3:0] OP_LED_OFF    = 4'd3;
    localparam logic [3:0] OP_ROW_MASK   = 4'd4;
    localparam logic [3:0] OP_COL_MASK   = 4'd5;
    localparam logic [3:0] OP_FRAME      = 4'd8;
    localparam logic [3:0] OP_FILL       = 4'd9;

    // Pixel job kinds
    localparam logic [1:0] JOB_FILL   = 2'd0;
    localparam logic [1:0] JOB_SINGLE = 2'd1;
    localparam logic [1:0] JOB_ROW    = 2'd2;
    localparam logic [1:0] JOB_COL    = 2'd3;

    // Parser state
    logic        awaiting_reg, awaiting_next;
    logic [7:0]  held_reg, held_next;
    logic [3:0]  dcount_reg, dcount_next;
    logic [15:0] staged_reg, staged_next;
    logic [23:0] draw_reg, draw_next;

    // Pixel job
    logic [1:0]      kind_reg, kind_next;
    logic [IdxW-1:0] fix_a_reg, fix_a_next;
    logic [IdxW-1:0] fix_b_reg, fix_b_next;
    logic [7:0]      mask_reg, mask_next;
    logic [3:0]      last_k_reg, last_k_next;
    logic [3:0]      k_reg, k_next;
    logic            pending;

    // Output register
    logic        out_valid_reg;
    logic [3:0]  index_reg;
    logic [23:0] colour_reg;
    logic        last_reg;

    logic [3:0] op, hop, arg, x_nib, y_nib, dcount_inc;

    assign op         = rx_byte[7:4];
    assign hop        = held_reg[7:4];
    assign arg        = held_reg[3:0];
    assign x_nib      = rx_byte[7:4];
    assign y_nib      = rx_byte[3:0];
    assign dcount_inc = dcount_reg + 4'd1;

    // Decode the incoming byte and set up the next parser state and job
    always_comb
    begin
        awaiting_next = awaiting_reg;
        held_next     = held_reg;
        dcount_next   = dcount_reg;
        staged_next   = staged_reg;
        draw_next     = draw_reg;
        kind_next     = kind_reg;
        fix_a_next    = fix_a_reg;
        fix_b_next    = fix_b_reg;
        mask_next     = mask_reg;
        last_k_next   = last_k_reg;
        pending       = 1'b0;

        if (awaiting_reg)
        begin
            held_next   = rx_byte;
            dcount_next = 4'd0;
            if (op == OP_SET_COLOUR || op == OP_LED_ON || op == OP_LED_OFF ||
                op == OP_ROW_MASK || op == OP_COL_MASK || op == OP_FRAME)
            begin
                awaiting_next = 1'b0;
            end
            else if (op == OP_FILL)
            begin
                pending     = 1'b1;
                kind_next   = JOB_FILL;
                mask_next   = {8{rx_byte[0]}};
                last_k_next = FillLast;
            end
        end
        else
        begin
            unique case (hop)
                OP_SET_COLOUR:
                begin
                    priority if (dcount_reg == 4'd0)
                    begin
                        staged_next = {rx_byte, 8'h00};
                        dcount_next = 4'd1;
                    end
                    else if (dcount_reg == 4'd1)
                    begin
                        staged_next = {staged_reg[15:8], rx_byte};
                        dcount_next = 4'd2;
                    end
                    else
                    begin
                        draw_next     = {staged_reg, rx_byte};
                        dcount_next   = 4'd0;
                        awaiting_next = 1'b1;
                    end
                end
                OP_LED_ON, OP_LED_OFF:
                begin
                    if (x_nib < SideNib && y_nib < SideNib)
                    begin
                        pending     = 1'b1;
                        kind_next   = JOB_SINGLE;
                        fix_a_next  = y_nib[IdxW-1:0];
                        fix_b_next  = x_nib[IdxW-1:0];
                        mask_next   = {8{hop == OP_LED_ON}};
                        last_k_next = 4'd0;
                    end
                    awaiting_next = 1'b1;
                end
                OP_ROW_MASK:
                begin
                    if (arg < SideNib)
                    begin
                        pending     = 1'b1;
                        kind_next   = JOB_ROW;
                        fix_a_next  = arg[IdxW-1:0];
                        mask_next   = rx_byte;
                        last_k_next = SideLast;
                    end
                    awaiting_next = 1'b1;
                end
                OP_COL_MASK:
                begin
                    if (arg < SideNib)
                    begin
                        pending     = 1'b1;
                        kind_next   = JOB_COL;
                        fix_b_next  = arg[IdxW-1:0];
                        mask_next   = rx_byte;
                        last_k_next = SideLast;
                    end
                    awaiting_next = 1'b1;
                end
                OP_FRAME:
                begin
                    if (dcount_reg < SideNib)
                    begin
                        pending     = 1'b1;
                        kind_next   = JOB_ROW;
                        fix_a_next  = dcount_reg[IdxW-1:0];
                        mask_next   = rx_byte;
                        last_k_next = SideLast;
                    end
                    dcount_next = dcount_inc;
                    if (dcount_inc >= SideNib)
                    begin
                        dcount_next   = 4'd0;
                        awaiting_next = 1'b1;
                    end
                end
                default:
                begin
                    dcount_next   = 4'd0;
                    awaiting_next = 1'b1;
                end
            endcase
        end
    end

    // Cell coordinates of the current write
    logic [IdxW-1:0] a_sel, b_sel, off;
    logic [PosW-1:0] serp_pos, pos;
    logic            colour_on;

    always_comb
    begin
        unique case (kind_reg)
            JOB_ROW:
            begin
                a_sel = fix_a_reg;
                b_sel = k_reg[IdxW-1:0];
            end
            JOB_COL:
            begin
                a_sel = k_reg[IdxW-1:0];
                b_sel = fix_b_reg;
            end
            default:
            begin
                a_sel = fix_a_reg;
                b_sel = fix_b_reg;
            end
        endcase
    end

    // Serpentine remap: even columns run from the last row up, odd columns from row 0 down
    assign off      = b_sel[0] ? a_sel : IdxW'(GRID_SIDE - 1) - a_sel;
    assign serp_pos = PosW'(b_sel) * PosW'(GRID_SIDE) + PosW'(off);
    assign pos      = (kind_reg == JOB_FILL) ? PosW'(k_reg) : serp_pos;
    assign colour_on = mask_reg[k_reg[2:0]];

    // Advance the write counter
    always_comb
    begin
        k_next = k_reg;
        if (cmd.load_byte && pending)
        begin
            k_next = 4'd0;
        end
        else if (cmd.emit_step)
        begin
            k_next = k_reg + 4'd1;
        end
    end

    // Hold parser and job state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            held_reg     <= 8'd0;
            dcount_reg   <= 4'd0;
            staged_reg   <= 16'd0;
            draw_reg     <= 24'd0;
            kind_reg     <= JOB_FILL;
            fix_a_reg    <= '0;
            fix_b_reg    <= '0;
            mask_reg     <= 8'd0;
            last_k_reg   <= 4'd0;
            k_reg        <= 4'd0;
        end
        else
        begin
            if (cmd.load_byte)
            begin
                awaiting_reg <= awaiting_next;
                held_reg     <= held_next;
                dcount_reg   <= dcount_next;
                staged_reg   <= staged_next;
                draw_reg     <= draw_next;
                kind_reg     <= kind_next;
                fix_a_reg    <= fix_a_next;
                fix_b_reg    <= fix_b_next;
                mask_reg     <= mask_next;
                last_k_reg   <= last_k_next;
            end
            k_reg <= k_next;
        end
    end

    // Output valid: set on a write, drop when the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg  <= 4'd0;
            colour_reg <= 24'd0;
            last_reg   <= 1'b0;
        end
        else if (cmd.emit_step)
        begin
            index_reg  <= pos[3:0];
            colour_reg <= colour_on ? draw_reg : 24'd0;
            last_reg   <= (k_reg == last_k_reg);
        end
    end

    assign status.job_pending = pending;
    assign status.job_last    = (k_reg == last_k_reg);
    assign status.slot_free   = !out_valid_reg || pix.ready;

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_index = index_reg;
    assign pix.red_level   = colour_reg[23:16];
    assign pix.green_level = colour_reg[15:8];
    assign pix.blue_level  = colour_reg[7:0];
    assign pix.last_write  = last_reg;

    `LGSCP_ASSERT_NXT(a_emit_fills_slot, cmd.emit_step, out_valid_reg, "write step left output empty")
    `LGSCP_ASSERT_IMM(a_k_in_range, cmd.emit_step, k_reg <= last_k_reg, "write counter overran job")
    `LGSCP_ASSERT_NXT(a_job_starts_at_zero, cmd.load_byte && pending, k_reg == 4'd0, "new job did not restart counter")

endmodule

`default_nettype wire

/* sv/lgscp_ctrl.sv */
// Controller state machine: takes bytes while idle, steps pixel writes out.
// Depends on lgscp_pkg and the assertion macro header.
`default_nettype none
`include "led_grid_serial_command_parser_top_macros.svh"

module lgscp_ctrl
    import lgscp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rx_valid,
    output logic               rx_ready,
    input  wire lgscp_status_t status,
    output lgscp_cmd_t         cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg, state_next;

    assign rx_ready      = (state_reg == ST_IDLE);
    assign cmd.load_byte = rx_valid && rx_ready;
    assign cmd.emit_step = (state_reg == ST_EMIT) && status.slot_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load_byte && status.job_pending)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit_step && status.job_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LGSCP_ASSERT_NXT(a_job_enters_emit, cmd.load_byte && status.job_pending, state_reg == ST_EMIT, "job did not start")
    `LGSCP_ASSERT_NXT(a_last_ends_emit, cmd.emit_step && status.job_last, state_reg == ST_IDLE, "job did not end")
    `LGSCP_ASSERT_IMM(a_load_or_emit, 1'b1, !(cmd.load_byte && cmd.emit_step), "load during write")

endmodule

`default_nettype wire

/* sv/led_grid_serial_command_parser_top.sv */
// Top level of the LED grid serial command parser.
// Depends on lgscp_pkg, the channel interfaces, lgscp_ctrl and lgscp_datapath.
//
//   channel  dir  payload                                      transaction
//   rx       in   rx_byte[7:0]                                 one serial byte
//   pix      out  pixel_index[3:0], red/green/blue_level[7:0],  one pixel write
//                 last_write
//
// A byte that writes no pixel does not block rx. A byte that writes pixels
// blocks rx until its writes are produced: one write for led on/off, GRID_SIDE
// for a row, column or frame byte, min(GRID_SIDE*GRID_SIDE, 16) for fill, set
// by the single write counter feeding the output register. A stalled pix sink
// holds the counter. The next byte is taken while the final write still waits.
// Reset returns the parser to idle with a black draw colour.
`default_nettype none

module led_grid_serial_command_parser_top
    import lgscp_pkg::*;
#(
    parameter int GRID_SIDE = 4
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lgscp_rx_if.sink    rx,
    lgscp_pix_if.source pix
);

    lgscp_cmd_t    cmd;
    lgscp_status_t status;
    logic          rx_ready;

    assign rx.ready = rx_ready;

    lgscp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lgscp_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (rx.rx_byte),
        .cmd     (cmd),
        .status  (status),
        .pix     (pix)
    );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the LED grid serial command parser top level.
// Depends on the RTL channel interfaces (lgscp_rx_if, lgscp_pix_if) and the DUT top module.

module tb_top;

    localparam int GRID         = 4;
    localparam int MAX_WRITES   = 16;
    localparam int RANDOM_ITEMS = 165;
    localparam int SETTLE_CYCLES = 24;

    // Opcodes carried in the high nibble of a command byte
    typedef enum logic [3:0] {
        OP_UNUSED_0   = 4'h0,
        OP_SET_COLOUR = 4'h1,
        OP_LED_ON     = 4'h2,
        OP_LED_OFF    = 4'h3,
        OP_ROW_MASK   = 4'h4,
        OP_COL_MASK   = 4'h5,
        OP_FRAME      = 4'h8,
        OP_FILL       = 4'h9,
        OP_ADC_ON     = 4'hC,
        OP_ADC_OFF    = 4'hD,
        OP_UNUSED_F   = 4'hF
    } opcode_t;

    // How a directed row gets its expected writes
    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_SILENT,
        ROW_SINGLE
    } row_kind_t;

    typedef struct packed {
        logic [3:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pix_write_t;

    typedef struct {
        logic [7:0]  data;
        row_kind_t   kind;
        logic [3:0]  idx;
        logic [23:0] rgb;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lgscp_rx_if  rx_ch();
    lgscp_pix_if pix_ch();

    led_grid_serial_command_parser_top #(
        .GRID_SIDE(GRID)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .pix   (pix_ch)
    );

    // Parser shadow state
    logic        at_idle;
    logic [7:0]  cmd_byte;
    logic [3:0]  data_cnt;
    logic [15:0] stage_rg;
    logic [23:0] paint_rgb;

    pix_write_t batch_q[$];
    pix_write_t pixel_q[$];

    int  fails          = 0;
    int  writes_checked = 0;
    int  bytes_sent     = 0;
    int  useful_items   = 0;
    int  fills_sent     = 0;
    int  rx_idle_pct    = 30;
    int  pix_idle_pct   = 30;
    bit  calm           = 1'b0;

    // Directed stimulus: extremes, every opcode, out-of-range cases
    stim_row_t dir_tab[27] = '{
        '{{OP_UNUSED_0, 4'h0},   ROW_SILENT,    4'd0,  24'h0},
        '{{OP_UNUSED_F, 4'hF},   ROW_SILENT,    4'd0,  24'h0},
        '{{OP_ADC_ON, 4'h0},     ROW_SILENT,    4'd0,  24'h0},
        '{{OP_ADC_OFF, 4'h5},    ROW_SILENT,    4'd0,  24'h0},
        '{{OP_FILL, 4'h0},       ROW_PREDICTED, 4'd0,  24'h0},
        '{{OP_SET_COLOUR, 4'h0}, ROW_SILENT,    4'd0,  24'h0},
        '{8'hFF,                 ROW_SILENT,    4'd0,  24'h0},
        '{8'h00,                 ROW_SILENT,    4'd0,  24'h0},
        '{8'h80,                 ROW_SILENT,    4'd0,  24'h0},
        '{{OP_LED_ON, 4'h0},     ROW_SILENT,    4'd0,  24'h0},
        '{8'h00,                 ROW_SINGLE,    4'd3,  24'hFF0080},
        '{{OP_LED_OFF, 4'h0},    ROW_SILENT,    4'd0,  24'h0},
        '{8'h33,                 ROW_SINGLE,    4'd15, 24'h000000},
        '{{OP_LED_ON, 4'hF},     ROW_SILENT,    4'd0,  24'h0},
        '{8'h44,                 ROW_SILENT,    4'd0,  24'h0},
        '{{OP_ROW_MASK, 4'h3},   ROW_SILENT,    4'd0,  24'h0},
        '{8'hFF,                 ROW_PREDICTED, 4'd0,  24'h0},
        '{{OP_ROW_MASK, 4'hF},   ROW_SILENT,    4'd0,  24'h0},
        '{8'hAA,                 ROW_SILENT,    4'd0,  24'h0},
        '{{OP_COL_MASK, 4'h0},   ROW_SILENT,    4'd0,  24'h0},
        '{8'h05,                 ROW_PREDICTED, 4'd0,  24'h0},
        '{{OP_FRAME, 4'h0},      ROW_SILENT,    4'd0,  24'h0},
        '{8'h0F,                 ROW_PREDICTED, 4'd0,  24'h0},
        '{8'hF0,                 ROW_PREDICTED, 4'd0,  24'h0},
        '{8'h5A,                 ROW_PREDICTED, 4'd0,  24'h0},
        '{8'hA5,                 ROW_PREDICTED, 4'd0,  24'h0},
        '{{OP_FILL, 4'h1},       ROW_PREDICTED, 4'd0,  24'h0}
    };

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Serpentine strip position of grid cell (row a, column b)
    function automatic logic [3:0] strip_pos(input int a, input int b);
        int off;
        off = (b % 2 != 0) ? a : GRID - 1 - a;
        return 4'(b * GRID + off);
    endfunction

    // Queue one pixel write, dropping any beyond the output limit
    function automatic void add_write(input int pos, input logic [23:0] rgb);
        if (batch_q.size() < MAX_WRITES)
            batch_q.push_back('{4'(pos), rgb[23:16], rgb[15:8], rgb[7:0], 1'b0});
    endfunction

    function automatic void paint_row(input int r, input logic [7:0] mask);
        for (int c = 0; c < GRID; c++)
            add_write(strip_pos(r, c), mask[c] ? paint_rgb : 24'h0);
    endfunction

    function automatic void paint_col(input int c, input logic [7:0] mask);
        for (int r = 0; r < GRID; r++)
            add_write(strip_pos(r, c), mask[r] ? paint_rgb : 24'h0);
    endfunction

    function automatic bit is_known_op(input logic [3:0] op);
        case (op)
            OP_SET_COLOUR, OP_LED_ON, OP_LED_OFF, OP_ROW_MASK, OP_COL_MASK,
            OP_FRAME, OP_FILL, OP_ADC_ON, OP_ADC_OFF: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Advance the shadow parser by one byte; leave its pixel writes in batch_q
    function automatic void predict_byte(input logic [7:0] data);
        logic [3:0] op;
        logic [3:0] arg;
        pix_write_t tail;
        batch_q.delete();
        if (at_idle)
        begin
            op       = data[7:4];
            cmd_byte = data;
            data_cnt = 4'd0;
            case (op)
                OP_SET_COLOUR, OP_LED_ON, OP_LED_OFF, OP_ROW_MASK, OP_COL_MASK, OP_FRAME:
                    at_idle = 1'b0;
                OP_FILL:
                    for (int x = 0; x < GRID * GRID; x++)
                        add_write(x, data[0] ? paint_rgb : 24'h0);
                default: ;
            endcase
        end
        else
        begin
            op  = cmd_byte[7:4];
            arg = cmd_byte[3:0];
            case (op)
                OP_SET_COLOUR:
                begin
                    if (data_cnt == 4'd0)
                    begin
                        stage_rg = {data, 8'h00};
                        data_cnt = 4'd1;
                    end
                    else if (data_cnt == 4'd1)
                    begin
                        stage_rg[7:0] = data;
                        data_cnt      = 4'd2;
                    end
                    else
                    begin
                        paint_rgb = {stage_rg, data};
                        data_cnt  = 4'd0;
                        at_idle   = 1'b1;
                    end
                end
                OP_LED_ON, OP_LED_OFF:
                begin
                    if (data[7:4] < GRID && data[3:0] < GRID)
                        add_write(strip_pos(data[3:0], data[7:4]),
                                  (op == OP_LED_ON) ? paint_rgb : 24'h0);
                    at_idle = 1'b1;
                end
                OP_ROW_MASK:
                begin
                    if (arg < GRID)
                        paint_row(arg, data);
                    at_idle = 1'b1;
                end
                OP_COL_MASK:
                begin
                    if (arg < GRID)
                        paint_col(arg, data);
                    at_idle = 1'b1;
                end
                OP_FRAME:
                begin
                    if (data_cnt < GRID)
                        paint_row(data_cnt, data);
                    data_cnt = data_cnt + 4'd1;
                    if (data_cnt >= GRID)
                    begin
                        data_cnt = 4'd0;
                        at_idle  = 1'b1;
                    end
                end
                default:
                begin
                    data_cnt = 4'd0;
                    at_idle  = 1'b1;
                end
            endcase
        end
        // Mark the final write of this byte
        if (batch_q.size() > 0)
        begin
            tail      = batch_q[batch_q.size() - 1];
            tail.last = 1'b1;
            batch_q[batch_q.size() - 1] = tail;
        end
    endfunction

    function automatic void flush_batch();
        foreach (batch_q[i])
            pixel_q.push_back(batch_q[i]);
    endfunction

    // Offer one byte on rx, with an optional idle gap, and hold until the transaction
    task automatic send_byte(input logic [7:0] data);
        int gap;
        if (!calm && $urandom_range(0, 99) < rx_idle_pct)
        begin
            gap = $urandom_range(1, 15);
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= data;
        do @(posedge clk); while (!rx_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_predicted(input logic [7:0] data);
        send_byte(data);
        predict_byte(data);
        flush_batch();
    endtask

    // Hold the sender until every expected write has come out
    task automatic wait_for_drain();
        rx_ch.valid <= 1'b0;
        do @(posedge clk); while (pixel_q.size() != 0);
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 40;
        endcase
    endfunction

    // Pixel sink: random stall bursts, none once the run winds down
    initial
    begin
        pix_ch.ready <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 99) < pix_idle_pct)
            begin
                pix_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            pix_ch.ready <= 1'b1;
        end
    end

    // Compare each pixel write transaction with the oldest expectation
    always @(posedge clk)
    begin : check_writes
        pix_write_t want;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            if (pixel_q.size() == 0)
            begin
                $error("unexpected pixel write: pixel_index %0d", pix_ch.pixel_index);
                fails++;
            end
            else
            begin
                want = pixel_q.pop_front();
                writes_checked++;
                if (pix_ch.pixel_index !== want.idx)
                begin
                    $error("pixel_index: expected %0d, got %0d", want.idx, pix_ch.pixel_index);
                    fails++;
                end
                if (pix_ch.red_level !== want.red)
                begin
                    $error("red_level: expected %0h, got %0h", want.red, pix_ch.red_level);
                    fails++;
                end
                if (pix_ch.green_level !== want.green)
                begin
                    $error("green_level: expected %0h, got %0h", want.green, pix_ch.green_level);
                    fails++;
                end
                if (pix_ch.blue_level !== want.blue)
                begin
                    $error("blue_level: expected %0h, got %0h", want.blue, pix_ch.blue_level);
                    fails++;
                end
                if (pix_ch.last_write !== want.last)
                begin
                    $error("last_write: expected %0b, got %0b", want.last, pix_ch.last_write);
                    fails++;
                end
            end
        end
    end

    // Stimulus, reset and verdict
    initial
    begin
        int          pick;
        int          len;
        logic [3:0]  op4;
        logic [7:0]  data;
        bit          pressure_done;

        pressure_done = 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        at_idle   = 1'b1;
        cmd_byte  = 8'h00;
        data_cnt  = 4'd0;
        stage_rg  = 16'h0;
        paint_rgb = 24'h0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        foreach (dir_tab[i])
        begin
            send_byte(dir_tab[i].data);
            predict_byte(dir_tab[i].data);
            case (dir_tab[i].kind)
                ROW_PREDICTED: flush_batch();
                ROW_SINGLE:
                    pixel_q.push_back('{dir_tab[i].idx, dir_tab[i].rgb[23:16],
                                        dir_tab[i].rgb[15:8], dir_tab[i].rgb[7:0], 1'b1});
                default: ;
            endcase
        end
        wait_for_drain();

        // Random part: mostly well-formed command sequences with random content
        while (useful_items < RANDOM_ITEMS)
        begin
            if (!pressure_done && useful_items >= RANDOM_ITEMS / 2)
            begin
                wait_for_drain();
                pressure_done = 1'b1;
            end
            if (useful_items >= RANDOM_ITEMS - 30)
                calm = 1'b1;
            if ($urandom_range(0, 15) == 0)
            begin
                rx_idle_pct  = pick_idle_pct();
                pix_idle_pct = pick_idle_pct();
            end

            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                send_predicted({OP_SET_COLOUR, 4'($urandom_range(0, 15))});
                repeat (3) send_predicted(8'($urandom()));
                useful_items += 4;
            end
            else if (pick < 30)
            begin
                op4 = $urandom_range(0, 1) ? OP_LED_ON : OP_LED_OFF;
                send_predicted({op4, 4'($urandom_range(0, 15))});
                if ($urandom_range(0, 4) == 0)
                    data = 8'($urandom());
                else
                    data = {4'($urandom_range(0, GRID - 1)), 4'($urandom_range(0, GRID - 1))};
                send_predicted(data);
                useful_items += 2;
            end
            else if (pick < 50)
            begin
                op4 = $urandom_range(0, 1) ? OP_ROW_MASK : OP_COL_MASK;
                if ($urandom_range(0, 4) == 0)
                    send_predicted({op4, 4'($urandom_range(0, 15))});
                else
                    send_predicted({op4, 4'($urandom_range(0, GRID - 1))});
                send_predicted(8'($urandom()));
                useful_items += 2;
            end
            else if (pick < 62)
            begin
                send_predicted({OP_FRAME, 4'($urandom_range(0, 15))});
                repeat (GRID) send_predicted(8'($urandom()));
                useful_items += 1 + GRID;
            end
            else if (pick < 75)
            begin
                send_predicted({OP_FILL, 4'($urandom_range(0, 15))});
                fills_sent++;
                useful_items += 1;
            end
            else if (pick < 82)
            begin
                op4 = $urandom_range(0, 1) ? OP_ADC_ON : OP_ADC_OFF;
                send_predicted({op4, 4'($urandom_range(0, 15))});
            end
            else if (pick < 90)
            begin
                do op4 = 4'($urandom_range(0, 15)); while (is_known_op(op4));
                send_predicted({op4, 4'($urandom_range(0, 15))});
            end
            else
            begin
                // Stray byte: may land as data and shift the sequence framing
                len = $urandom_range(1, 2);
                repeat (len) send_predicted(8'($urandom()));
            end
        end

        // Drain and let any stray writes show up
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pixel_q.size() != 0)
        begin
            $error("%0d expected pixel writes never arrived", pixel_q.size());
            fails++;
        end

        $display("Run covered %0d serial bytes (%0d directed, %0d random fill/clear commands)",
                 bytes_sent, $size(dir_tab), fills_sent);
        $display("and checked %0d pixel writes field by field under random stalls.",
                 writes_checked);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* led_grid_serial_command_parser_top.f */
+incdir+sv
sv/lgscp_pkg.sv
sv/lgscp_rx_if.sv
sv/lgscp_datapath.sv
sv/lgscp_ctrl.sv
sv/led_grid_serial_command_parser_top.sv
tb/tb_top.sv
